### sv/pfs_pkg.sv
// pfs_pkg: shared widths, codes and types for the page frame free stack
// no dependencies; used by pfs_range, page_frame_free_stack and pfs_checker

package pfs_pkg;

   // fixed field widths
   localparam int PAGE_W = 12;
   localparam int CNT_W  = 13;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 2;

   // largest page number space the page field can name
   localparam int PAGE_SPAN = 4096;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOMEM  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_TWICE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RAM_PAGES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_PAGES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_FIRST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_END   = 2'd3;

   // register reset values
   localparam logic [CNT_W-1:0] RST_RAM_PAGES      = 13'h1000;
   localparam logic [CNT_W-1:0] RST_KERNEL_PAGES   = 13'h0100;
   localparam logic [CNT_W-1:0] RST_RESERVED_FIRST = 13'h009F;
   localparam logic [CNT_W-1:0] RST_RESERVED_END   = 13'h0100;

   // configuration seen by the page range unit
   typedef struct packed {
      logic [CNT_W-1:0] kernel_pages;
      logic [CNT_W-1:0] reserved_first;
      logic [CNT_W-1:0] reserved_end;
      logic [CNT_W-1:0] page_limit;
   } cfg_type;

   // page range verdict
   typedef struct packed {
      logic mapped;   // page is 1 .. limit-1
      logic listed;   // page belongs on the stack after a build
   } range_type;

endpackage

### sv/pfs_ram.sv
// pfs_ram: simple dual-port memory, one write and one registered read a cycle
// no dependencies

module pfs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pfs_range.sv
// pfs_range: shared page range compare unit, used by the build sweep and by free
// depends on pfs_pkg

module pfs_range (
   input  logic [pfs_pkg::CNT_W-1:0] page,
   input  pfs_pkg::cfg_type          cfg,
   output pfs_pkg::range_type        verdict
);

   logic in_window;

   // page zero and pages at or beyond the limit are unmapped
   assign verdict.mapped = (page != '0) && (page < cfg.page_limit);

   // an empty or inverted window never matches
   assign in_window = (page >= cfg.reserved_first) && (page < cfg.reserved_end);

   assign verdict.listed = verdict.mapped && (page >= cfg.kernel_pages) && !in_window;

endmodule

### sv/page_frame_free_stack.sv
// page_frame_free_stack: top level, sequencer, configuration registers
// depends on pfs_pkg, pfs_ram, pfs_range

// Physical page allocator: a LIFO stack of free page numbers plus one free
// mark per page, both in on-chip memory of min(MAX_PAGES, 4096) entries.
// A command is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high, and
// the receiver cannot stall it. Allocate and free make one memory read,
// then the write-back and result, a refused double free included; an
// allocate on an empty stack, a free of an unmapped page and an unknown
// command answer straight from idle. A build sweeps every page slot
// through the shared range unit, one page a cycle with busy high, and the
// result comes in the cycle after the last slot. After reset, busy stays
// high for a clearing pass over every page slot that clears the free
// marks; configuration writes are taken at any time but should only be
// made while idle.

module page_frame_free_stack #(
   parameter int MAX_PAGES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [pfs_pkg::FUNC_W-1:0]  req_func,
   input  logic [pfs_pkg::PAGE_W-1:0]  req_page,
   // result channel
   output logic                        rsp_strobe,
   output logic [pfs_pkg::PAGE_W-1:0]  rsp_page_out,
   output logic [pfs_pkg::STAT_W-1:0]  rsp_status,
   output logic [pfs_pkg::CNT_W-1:0]   rsp_free_count,
   // register write port
   input  logic                        csr_we,
   input  logic [pfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfs_pkg::CNT_W-1:0]   csr_wdata
);

   localparam int DEPTH = (MAX_PAGES < pfs_pkg::PAGE_SPAN) ? MAX_PAGES : pfs_pkg::PAGE_SPAN;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [pfs_pkg::CNT_W-1:0] DEPTH_CNT = pfs_pkg::CNT_W'(DEPTH);
   localparam logic [pfs_pkg::CNT_W-1:0] LAST_SLOT = pfs_pkg::CNT_W'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_POP   = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [pfs_pkg::CNT_W-1:0]  ram_pages_ff;
   logic [pfs_pkg::CNT_W-1:0]  kernel_pages_ff;
   logic [pfs_pkg::CNT_W-1:0]  reserved_first_ff;
   logic [pfs_pkg::CNT_W-1:0]  reserved_end_ff;

   logic [pfs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pfs_pkg::CNT_W-1:0]  walk_ff, walk_in;
   logic                       reply_ff, reply_in;
   logic [pfs_pkg::PAGE_W-1:0] page_ff, page_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [pfs_pkg::PAGE_W-1:0] rsp_page_ff, rsp_page_in;
   logic [pfs_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [pfs_pkg::CNT_W-1:0]  rsp_count_ff;

   logic [pfs_pkg::CNT_W-1:0]  count_dec;
   logic [pfs_pkg::CNT_W-1:0]  chk_page;
   pfs_pkg::cfg_type           cfg;
   pfs_pkg::range_type         verdict;
   logic                       sweep_push;

   logic                       stk_we;
   logic [AW-1:0]              stk_waddr;
   logic [pfs_pkg::PAGE_W-1:0] stk_wdata;
   logic [AW-1:0]              stk_raddr;
   logic [pfs_pkg::PAGE_W-1:0] stk_rdata;

   logic                       mrk_we;
   logic [AW-1:0]              mrk_waddr;
   logic                       mrk_wdata;
   logic [AW-1:0]              mrk_raddr;
   logic                       mrk_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_pages_ff      <= pfs_pkg::RST_RAM_PAGES;
         kernel_pages_ff   <= pfs_pkg::RST_KERNEL_PAGES;
         reserved_first_ff <= pfs_pkg::RST_RESERVED_FIRST;
         reserved_end_ff   <= pfs_pkg::RST_RESERVED_END;
      end else if (csr_we) begin
         unique case (csr_index)
            pfs_pkg::REG_RAM_PAGES:      ram_pages_ff      <= csr_wdata;
            pfs_pkg::REG_KERNEL_PAGES:   kernel_pages_ff   <= csr_wdata;
            pfs_pkg::REG_RESERVED_FIRST: reserved_first_ff <= csr_wdata;
            pfs_pkg::REG_RESERVED_END:   reserved_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // page limit is the smaller of installed ram and the store depth
   assign cfg.page_limit     = (ram_pages_ff > DEPTH_CNT) ? DEPTH_CNT : ram_pages_ff;
   assign cfg.kernel_pages   = kernel_pages_ff;
   assign cfg.reserved_first = reserved_first_ff;
   assign cfg.reserved_end   = reserved_end_ff;

   // shared range unit: sweep slot while building, command page otherwise
   assign chk_page = (state_ff == ST_SWEEP) ? walk_ff : {1'b0, req_page};

   pfs_range u_range (
      .page    (chk_page),
      .cfg     (cfg),
      .verdict (verdict)
   );

   // clearing pass after reset pushes nothing
   assign sweep_push = verdict.listed && reply_ff;
   assign count_dec  = count_ff - 1'b1;

   // stack of free page numbers
   pfs_ram #(
      .WIDTH (pfs_pkg::PAGE_W),
      .DEPTH (DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // free mark per page
   pfs_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_mark (
      .clock   (clock),
      .wr_en   (mrk_we),
      .wr_addr (mrk_waddr),
      .wr_data (mrk_wdata),
      .rd_addr (mrk_raddr),
      .rd_data (mrk_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      reply_in      = reply_ff;
      page_in       = page_ff;
      rsp_strobe_in = 1'b0;
      rsp_page_in   = '0;
      rsp_status_in = pfs_pkg::STAT_OK;
      stk_we        = 1'b0;
      stk_waddr     = count_ff[AW-1:0];
      stk_wdata     = page_ff;
      stk_raddr     = count_dec[AW-1:0];
      mrk_we        = 1'b0;
      mrk_waddr     = page_ff[AW-1:0];
      mrk_wdata     = 1'b0;
      mrk_raddr     = req_page[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               page_in = req_page;
               unique case (req_func)
                  pfs_pkg::FUNC_BUILD: begin
                     state_in = ST_SWEEP;
                     walk_in  = '0;
                     count_in = '0;
                     reply_in = 1'b1;
                  end
                  pfs_pkg::FUNC_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = pfs_pkg::STAT_NOMEM;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  pfs_pkg::FUNC_FREE: begin
                     if (!verdict.mapped) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = pfs_pkg::STAT_ABSENT;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // one page slot a cycle: rewrite its mark, push it if listed
         ST_SWEEP: begin
            mrk_we    = 1'b1;
            mrk_waddr = walk_ff[AW-1:0];
            mrk_wdata = sweep_push;
            stk_wdata = walk_ff[pfs_pkg::PAGE_W-1:0];
            if (sweep_push) begin
               stk_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (walk_ff == LAST_SLOT) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = reply_ff;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end

         // top entry has been read: clear its mark and hand it out
         ST_POP: begin
            mrk_we        = 1'b1;
            mrk_waddr     = stk_rdata[AW-1:0];
            count_in      = count_dec;
            rsp_strobe_in = 1'b1;
            rsp_page_in   = stk_rdata;
            state_in      = ST_IDLE;
         end

         // mark has been read: refuse a double free, else push
         ST_CHECK: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (mrk_rdata) begin
               rsp_status_in = pfs_pkg::STAT_TWICE;
            end else begin
               stk_we    = 1'b1;
               mrk_we    = 1'b1;
               mrk_wdata = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         count_ff      <= '0;
         walk_ff       <= '0;
         reply_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         reply_ff      <= reply_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_count_ff;

endmodule

### sv/pfs_checker.sv
// pfs_checker: port-level checks on the page frame free stack, bound to the top
// depends on pfs_pkg and page_frame_free_stack

module pfs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [pfs_pkg::PAGE_W-1:0]  rsp_page_out,
   input logic [pfs_pkg::STAT_W-1:0]  rsp_status,
   input logic [pfs_pkg::CNT_W-1:0]   rsp_free_count
);

   // clearing pass holds off commands right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("block not busy after reset");

   // a result beat only follows an accepted command or work in progress
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result beat without a command");

   // out of memory means an empty stack and no page
   a_nomem_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == pfs_pkg::STAT_NOMEM) |->
         (rsp_free_count == '0 && rsp_page_out == '0))
      else $error("out of memory with pages left");

   // a page is only handed out with ok status
   a_page_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_page_out != '0) |-> (rsp_status == pfs_pkg::STAT_OK))
      else $error("page returned with failing status");

   // page zero is never stacked, so the count stays below the page span
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_free_count < 13'd4096))
      else $error("free count out of range");

endmodule

bind page_frame_free_stack pfs_checker u_pfs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_page_out   (rsp_page_out),
   .rsp_status     (rsp_status),
   .rsp_free_count (rsp_free_count)
);
